FILE: rtl/msqs_pkg.sv
`timescale 1ns / 1ps

package msqs_pkg;

   // Fixed field widths of the request, response and configuration ports.
   localparam int TIME_IN_W  = 32;
   localparam int TIME_EXT_W = 48;
   localparam int AREA_W     = 64;
   localparam int COUNT_W    = 32;
   localparam int FREE_W     = 7;
   localparam int LONGEST_W  = 11;
   localparam int KIND_W     = 2;

   // Free server count saturates at the top of its register.
   localparam logic [FREE_W-1:0] FREE_MAX = 7'd127;

   // Event kinds carried by req_type.
   typedef enum logic [KIND_W-1:0] {
      EV_ARRIVAL   = 2'd0,
      EV_DEPARTURE = 2'd1,
      EV_CLOSE     = 2'd2
   } event_kind_type;

endpackage

FILE: rtl/multi_server_queue_statistics.sv
// Items pass the input register, then the result register; a held result stalls the input stage.
// Throughput: one item per cycle while rsp_ready stays high; the whole run-state update is a single
// pass, and the head entry of the arrival memory is kept prefetched through its one read port.
// Reset (synchronous, active high) clears all counts, areas, time marks and pointers, and loads
// one server; the arrival memory is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module multi_server_queue_statistics #(
   parameter int WAIT_DEPTH = 1024,
   parameter int TIME_BITS  = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [msqs_pkg::FREE_W-1:0]           csr_server_count,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [msqs_pkg::KIND_W-1:0]           req_type,
   input  logic [msqs_pkg::TIME_IN_W-1:0]        req_event_time,
   input  logic [msqs_pkg::TIME_IN_W-1:0]        req_carried_delay,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_service_started,
   output logic [msqs_pkg::TIME_IN_W-1:0]        rsp_started_wait,
   output logic                                  rsp_store_overflow,
   output logic [msqs_pkg::COUNT_W-1:0]          rsp_served_total,
   output logic [msqs_pkg::LONGEST_W-1:0]        rsp_longest_queue,
   output logic [msqs_pkg::AREA_W-1:0]           rsp_queue_area,
   output logic [msqs_pkg::AREA_W-1:0]           rsp_system_area,
   output logic [msqs_pkg::AREA_W-1:0]           rsp_idle_area,
   output logic [msqs_pkg::AREA_W-1:0]           rsp_wait_sum,
   output logic [msqs_pkg::AREA_W-1:0]           rsp_empty_queue_time
);

   import msqs_pkg::*;

   localparam int PTR_W   = $clog2(WAIT_DEPTH);
   localparam int WCNT_W  = $clog2(WAIT_DEPTH + 1);
   localparam int SCNT_W  = $clog2(WAIT_DEPTH + int'(FREE_MAX) + 1);
   localparam int LQ_EXT_W = (WCNT_W > LONGEST_W) ? WCNT_W : LONGEST_W;

   // Elapsed time that never goes negative.
   function automatic logic [TIME_BITS-1:0] span(input logic [TIME_BITS-1:0] now,
                                                 input logic [TIME_BITS-1:0] then);
      span = (now >= then) ? (now - then) : '0;
   endfunction

   // Circular pointer step over the memory depth.
   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] ptr);
      next_slot = (ptr == PTR_W'(WAIT_DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   // Input stage.
   logic                    s1_valid_ff, s1_valid_in;
   logic [KIND_W-1:0]       s1_type_ff;
   logic [TIME_IN_W-1:0]    s1_time_ff;
   logic [TIME_IN_W-1:0]    s1_delay_ff;
   logic                    advance;

   // Run state.
   logic [FREE_W-1:0]       server_count_ff, server_count_in;
   logic [FREE_W-1:0]       free_ff, free_in;
   logic [WCNT_W-1:0]       waiting_ff, waiting_in;
   logic [SCNT_W-1:0]       system_ff, system_in;
   logic [COUNT_W-1:0]      departed_ff, departed_in;
   logic [WCNT_W-1:0]       max_wait_ff, max_wait_in;
   logic [AREA_W-1:0]       q_int_ff, q_int_in;
   logic [AREA_W-1:0]       sys_int_ff, sys_int_in;
   logic [AREA_W-1:0]       idle_int_ff, idle_int_in;
   logic [AREA_W-1:0]       delay_tot_ff, delay_tot_in;
   logic [AREA_W-1:0]       empty_tot_ff, empty_tot_in;
   logic [TIME_BITS-1:0]    last_q_ff, last_q_in;
   logic [TIME_BITS-1:0]    last_idle_ff, last_idle_in;
   logic [TIME_BITS-1:0]    last_sys_ff, last_sys_in;
   logic [TIME_BITS-1:0]    empty_since_ff, empty_since_in;
   logic [PTR_W-1:0]        head_ff, head_in;
   logic [PTR_W-1:0]        tail_ff, tail_in;

   // Arrival memory with its prefetched head entry.
   logic [TIME_BITS-1:0]    arrival_store_ff [WAIT_DEPTH];
   logic [TIME_BITS-1:0]    head_data_ff;
   logic                    mem_we;

   // Result register.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    started_ff, started_in;
   logic [TIME_IN_W-1:0]    wait_out_ff, wait_out_in;
   logic                    overflow_ff, overflow_in;
   logic [COUNT_W-1:0]      served_ff;
   logic [LONGEST_W-1:0]    longest_ff, longest_in;
   logic [AREA_W-1:0]       res_q_ff, res_sys_ff, res_idle_ff, res_delay_ff, res_empty_ff;

   // Per-item terms.
   logic [TIME_EXT_W-1:0]   time_ext, delay_ext, wait_ext;
   logic [TIME_BITS-1:0]    t_now, d_now;
   logic [TIME_BITS-1:0]    span_sys, span_q, span_idle, span_empty, span_head;
   logic [TIME_BITS+SCNT_W-1:0] sys_prod;
   logic [TIME_BITS+WCNT_W-1:0] q_prod;
   logic [TIME_BITS+FREE_W-1:0] idle_prod;
   logic [LQ_EXT_W-1:0]     longest_ext;
   logic                    clear_run, csr_write;

   // Handshakes: the input stage moves on whenever the result register can take an item.
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || advance;
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid;
   assign s1_valid_in  = (req_valid && req_ready) || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   // Time fields reduced to the internal time width.
   assign time_ext  = TIME_EXT_W'(s1_time_ff);
   assign delay_ext = TIME_EXT_W'(s1_delay_ff);
   assign t_now     = time_ext[TIME_BITS-1:0];
   assign d_now     = delay_ext[TIME_BITS-1:0];

   // Elapsed spans and area increments, all taken from the state before the item.
   assign span_sys   = span(t_now, last_sys_ff);
   assign span_q     = span(t_now, last_q_ff);
   assign span_idle  = span(t_now, last_idle_ff);
   assign span_empty = span(t_now, empty_since_ff);
   assign span_head  = span(t_now, head_data_ff);
   assign sys_prod   = span_sys * system_ff;
   assign q_prod     = span_q * waiting_ff;
   assign idle_prod  = span_idle * free_ff;
   assign wait_ext   = TIME_EXT_W'(span_head);

   // Event handling and run-state update.
   always_comb begin
      server_count_in = server_count_ff;
      free_in         = free_ff;
      waiting_in      = waiting_ff;
      system_in       = system_ff;
      departed_in     = departed_ff;
      max_wait_in     = max_wait_ff;
      q_int_in        = q_int_ff;
      sys_int_in      = sys_int_ff;
      idle_int_in     = idle_int_ff;
      delay_tot_in    = delay_tot_ff;
      empty_tot_in    = empty_tot_ff;
      last_q_in       = last_q_ff;
      last_idle_in    = last_idle_ff;
      last_sys_in     = last_sys_ff;
      empty_since_in  = empty_since_ff;
      head_in         = head_ff;
      tail_in         = tail_ff;
      started_in      = 1'b0;
      wait_out_in     = '0;
      overflow_in     = 1'b0;
      mem_we          = 1'b0;
      clear_run       = 1'b0;
      if (advance) begin
         case (event_kind_type'(s1_type_ff))
            EV_ARRIVAL: begin
               if (free_ff == '0 && waiting_ff >= WCNT_W'(WAIT_DEPTH)) begin
                  overflow_in = 1'b1;
               end else begin
                  sys_int_in  = sys_int_ff + AREA_W'(sys_prod);
                  last_sys_in = t_now;
                  system_in   = system_ff + 1'b1;
                  if (free_ff != '0) begin
                     idle_int_in  = idle_int_ff + AREA_W'(idle_prod);
                     last_idle_in = t_now;
                     free_in      = free_ff - 1'b1;
                     started_in   = 1'b1;
                  end else begin
                     if (waiting_ff == '0) begin
                        empty_tot_in = empty_tot_ff + AREA_W'(span_empty);
                     end
                     q_int_in   = q_int_ff + AREA_W'(q_prod);
                     last_q_in  = t_now;
                     waiting_in = waiting_ff + 1'b1;
                     if (waiting_in > max_wait_ff) begin
                        max_wait_in = waiting_in;
                     end
                     mem_we  = 1'b1;
                     tail_in = next_slot(tail_ff);
                  end
               end
            end
            EV_DEPARTURE: begin
               if (system_ff != '0) begin
                  sys_int_in   = sys_int_ff + AREA_W'(sys_prod);
                  last_sys_in  = t_now;
                  system_in    = system_ff - 1'b1;
                  departed_in  = departed_ff + 1'b1;
                  delay_tot_in = delay_tot_ff + AREA_W'(d_now);
                  if (waiting_ff != '0) begin
                     q_int_in   = q_int_ff + AREA_W'(q_prod);
                     last_q_in  = t_now;
                     waiting_in = waiting_ff - 1'b1;
                     if (waiting_in == '0) begin
                        empty_since_in = t_now;
                     end
                     wait_out_in = wait_ext[TIME_IN_W-1:0];
                     head_in     = next_slot(head_ff);
                     started_in  = 1'b1;
                  end else begin
                     idle_int_in  = idle_int_ff + AREA_W'(idle_prod);
                     last_idle_in = t_now;
                     if (free_ff < FREE_MAX) begin
                        free_in = free_ff + 1'b1;
                     end
                  end
               end
            end
            EV_CLOSE: begin
               q_int_in     = q_int_ff + AREA_W'(q_prod);
               sys_int_in   = sys_int_ff + AREA_W'(sys_prod);
               idle_int_in  = idle_int_ff + AREA_W'(idle_prod);
               if (waiting_ff == '0) begin
                  empty_tot_in = empty_tot_ff + AREA_W'(span_empty);
               end
               clear_run = 1'b1;
            end
            default: begin
            end
         endcase
      end

      // Totals are reported before any clearing of the run.
      longest_ext = LQ_EXT_W'(max_wait_in);
      longest_in  = longest_ext[LONGEST_W-1:0];

      // A close-out or a server count write starts a fresh run.
      if (csr_write) begin
         server_count_in = csr_server_count;
      end
      if (clear_run || csr_write) begin
         free_in        = server_count_in;
         waiting_in     = '0;
         system_in      = '0;
         departed_in    = '0;
         max_wait_in    = '0;
         q_int_in       = '0;
         sys_int_in     = '0;
         idle_int_in    = '0;
         delay_tot_in   = '0;
         empty_tot_in   = '0;
         last_q_in      = '0;
         last_idle_in   = '0;
         last_sys_in    = '0;
         empty_since_in = '0;
         head_in        = '0;
         tail_in        = '0;
      end
   end

   // Control and run-state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         server_count_ff <= FREE_W'(1);
         free_ff         <= FREE_W'(1);
         waiting_ff      <= '0;
         system_ff       <= '0;
         departed_ff     <= '0;
         max_wait_ff     <= '0;
         q_int_ff        <= '0;
         sys_int_ff      <= '0;
         idle_int_ff     <= '0;
         delay_tot_ff    <= '0;
         empty_tot_ff    <= '0;
         last_q_ff       <= '0;
         last_idle_ff    <= '0;
         last_sys_ff     <= '0;
         empty_since_ff  <= '0;
         head_ff         <= '0;
         tail_ff         <= '0;
      end else begin
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         server_count_ff <= server_count_in;
         free_ff         <= free_in;
         waiting_ff      <= waiting_in;
         system_ff       <= system_in;
         departed_ff     <= departed_in;
         max_wait_ff     <= max_wait_in;
         q_int_ff        <= q_int_in;
         sys_int_ff      <= sys_int_in;
         idle_int_ff     <= idle_int_in;
         delay_tot_ff    <= delay_tot_in;
         empty_tot_ff    <= empty_tot_in;
         last_q_ff       <= last_q_in;
         last_idle_ff    <= last_idle_in;
         last_sys_ff     <= last_sys_in;
         empty_since_ff  <= empty_since_in;
         head_ff         <= head_in;
         tail_ff         <= tail_in;
      end
   end

   // Input item register.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_type_ff  <= req_type;
         s1_time_ff  <= req_event_time;
         s1_delay_ff <= req_carried_delay;
      end
   end

   // Result register; the reported totals are the values after the item.
   always_ff @(posedge clock) begin
      if (advance) begin
         started_ff   <= started_in;
         wait_out_ff  <= wait_out_in;
         overflow_ff  <= overflow_in;
         served_ff    <= clear_run ? departed_ff : departed_in;
         longest_ff   <= longest_in;
         res_q_ff     <= clear_run ? q_int_ff + AREA_W'(q_prod) : q_int_in;
         res_sys_ff   <= clear_run ? sys_int_ff + AREA_W'(sys_prod) : sys_int_in;
         res_idle_ff  <= clear_run ? idle_int_ff + AREA_W'(idle_prod) : idle_int_in;
         res_delay_ff <= clear_run ? delay_tot_ff : delay_tot_in;
         res_empty_ff <= (clear_run && waiting_ff == '0) ?
                         empty_tot_ff + AREA_W'(span_empty) :
                         (clear_run ? empty_tot_ff : empty_tot_in);
      end
   end

   // Arrival memory; the head entry is read ahead, and a write to that entry is forwarded.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         arrival_store_ff[tail_ff] <= t_now;
      end
      if (mem_we && tail_ff == head_in) begin
         head_data_ff <= t_now;
      end else begin
         head_data_ff <= arrival_store_ff[head_in];
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_service_started  = started_ff;
   assign rsp_started_wait     = wait_out_ff;
   assign rsp_store_overflow   = overflow_ff;
   assign rsp_served_total     = served_ff;
   assign rsp_longest_queue    = longest_ff;
   assign rsp_queue_area       = res_q_ff;
   assign rsp_system_area      = res_sys_ff;
   assign rsp_idle_area        = res_idle_ff;
   assign rsp_wait_sum         = res_delay_ff;
   assign rsp_empty_queue_time = res_empty_ff;

   // Customers wait only while every server is busy.
   assert property (@(posedge clock) disable iff (reset)
      waiting_ff != '0 |-> free_ff == '0)
      else $error("customers waiting while a server is free");

   // The waiting count never passes the memory depth.
   assert property (@(posedge clock) disable iff (reset)
      waiting_ff <= WCNT_W'(WAIT_DEPTH))
      else $error("waiting count beyond memory depth");

   // An empty queue has its memory pointers together.
   assert property (@(posedge clock) disable iff (reset)
      waiting_ff == '0 |-> head_ff == tail_ff)
      else $error("memory pointers apart with an empty queue");

   // A close-out leaves an empty station behind.
   assert property (@(posedge clock) disable iff (reset)
      advance && s1_type_ff == EV_CLOSE |=> system_ff == '0 && waiting_ff == '0)
      else $error("station not empty after close-out");

   // Dropping an arrival never also starts a service.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(overflow_ff && started_ff))
      else $error("overflow and service start in one result");

endmodule

FILE: tb/multi_server_queue_statistics_checker.sv
`timescale 1ns / 1ps

module multi_server_queue_statistics_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [msqs_pkg::FREE_W-1:0]    csr_server_count,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [msqs_pkg::KIND_W-1:0]    req_type,
   input  logic [msqs_pkg::TIME_IN_W-1:0] req_event_time,
   input  logic [msqs_pkg::TIME_IN_W-1:0] req_carried_delay,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic                           rsp_service_started,
   input  logic [msqs_pkg::TIME_IN_W-1:0] rsp_started_wait,
   input  logic                           rsp_store_overflow,
   input  logic [msqs_pkg::COUNT_W-1:0]   rsp_served_total,
   input  logic [msqs_pkg::LONGEST_W-1:0] rsp_longest_queue,
   input  logic [msqs_pkg::AREA_W-1:0]    rsp_queue_area,
   input  logic [msqs_pkg::AREA_W-1:0]    rsp_system_area,
   input  logic [msqs_pkg::AREA_W-1:0]    rsp_idle_area,
   input  logic [msqs_pkg::AREA_W-1:0]    rsp_wait_sum,
   input  logic [msqs_pkg::AREA_W-1:0]    rsp_empty_queue_time,
   output int                             fail_count,
   output int                             outstanding
);
   import msqs_pkg::*;

   localparam int STORE_DEPTH = 1024;

   typedef logic [TIME_IN_W-1:0] stamp_type;
   typedef logic [AREA_W-1:0]    area_type;

   // Everything one item is expected to report.
   typedef struct {
      logic                 started;
      stamp_type            start_wait;
      logic                 overflow;
      logic [COUNT_W-1:0]   served;
      logic [LONGEST_W-1:0] longest;
      area_type             q_area;
      area_type             sys_area;
      area_type             idle_area;
      area_type             waits;
      area_type             empty_time;
   } outcome_type;

   outcome_type expected_q[$];

   // Predicted state of the queueing station.
   logic [FREE_W-1:0]    servers_cfg;
   logic [FREE_W-1:0]    servers_free;
   logic [LONGEST_W-1:0] waiting;
   logic [LONGEST_W-1:0] peak_waiting;
   logic [11:0]          in_system;
   logic [COUNT_W-1:0]   departures;
   area_type             queue_acc;
   area_type             system_acc;
   area_type             idle_acc;
   area_type             wait_acc;
   area_type             empty_acc;
   stamp_type            queue_mark;
   stamp_type            system_mark;
   stamp_type            idle_mark;
   stamp_type            empty_start;
   stamp_type            arrival_time [STORE_DEPTH];
   logic [9:0]           head_ptr;
   logic [9:0]           tail_ptr;

   // Elapsed time between two stamps; a clock running backward counts as zero.
   function automatic area_type elapsed(stamp_type now, stamp_type since);
      return (now >= since) ? area_type'(now - since) : '0;
   endfunction

   task automatic clear_run();
      servers_free = servers_cfg;
      waiting      = '0;
      peak_waiting = '0;
      in_system    = '0;
      departures   = '0;
      queue_acc    = '0;
      system_acc   = '0;
      idle_acc     = '0;
      wait_acc     = '0;
      empty_acc    = '0;
      queue_mark   = '0;
      system_mark  = '0;
      idle_mark    = '0;
      empty_start  = '0;
      head_ptr     = '0;
      tail_ptr     = '0;
   endtask

   // Each area is brought up to time t at the old count before the count moves.
   task automatic close_queue_area(stamp_type t);
      queue_acc += elapsed(t, queue_mark) * area_type'(waiting);
      queue_mark = t;
   endtask

   task automatic close_system_area(stamp_type t);
      system_acc += elapsed(t, system_mark) * area_type'(in_system);
      system_mark = t;
   endtask

   task automatic close_idle_area(stamp_type t);
      idle_acc += elapsed(t, idle_mark) * area_type'(servers_free);
      idle_mark = t;
   endtask

   task automatic apply_item(logic [KIND_W-1:0] kind, stamp_type t, stamp_type dly);
      outcome_type res;
      logic        restart;
      res         = '{default: '0};
      restart     = 1'b0;
      case (kind)
         EV_ARRIVAL: begin
            if (servers_free == 0 && waiting >= STORE_DEPTH) begin
               // Store full and nobody free: the customer is turned away.
               res.overflow = 1'b1;
            end else begin
               close_system_area(t);
               in_system++;
               if (servers_free != 0) begin
                  close_idle_area(t);
                  servers_free--;
                  res.started = 1'b1;
               end else begin
                  if (waiting == 0) empty_acc += elapsed(t, empty_start);
                  close_queue_area(t);
                  waiting++;
                  if (waiting > peak_waiting) peak_waiting = waiting;
                  arrival_time[tail_ptr] = t;
                  tail_ptr++;
               end
            end
         end
         EV_DEPARTURE: begin
            // A departure from an empty station changes nothing.
            if (in_system != 0) begin
               close_system_area(t);
               in_system--;
               departures++;
               wait_acc += area_type'(dly);
               if (waiting != 0) begin
                  close_queue_area(t);
                  waiting--;
                  if (waiting == 0) empty_start = t;
                  res.start_wait = stamp_type'(elapsed(t, arrival_time[head_ptr]));
                  res.started    = 1'b1;
                  head_ptr++;
               end else begin
                  close_idle_area(t);
                  if (servers_free < FREE_MAX) servers_free++;
               end
            end
         end
         EV_CLOSE: begin
            close_queue_area(t);
            close_system_area(t);
            if (waiting == 0) empty_acc += elapsed(t, empty_start);
            close_idle_area(t);
            restart = 1'b1;
         end
         default: begin
         end
      endcase
      res.served     = departures;
      res.longest    = peak_waiting;
      res.q_area     = queue_acc;
      res.sys_area   = system_acc;
      res.idle_area  = idle_acc;
      res.waits      = wait_acc;
      res.empty_time = empty_acc;
      expected_q = {expected_q, res};
      if (restart) clear_run();
   endtask

   task automatic flag_mismatch(string what, area_type got, area_type want);
      $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
      fail_count++;
   endtask

   task automatic check_result();
      outcome_type want;
      if (expected_q.size() == 0) begin
         flag_mismatch("unexpected result, served_total", area_type'(rsp_served_total), '0);
      end else begin
         want = expected_q[0];
         expected_q.delete(0);
         if (rsp_service_started !== want.started)
            flag_mismatch("service_started", area_type'(rsp_service_started),
                          area_type'(want.started));
         if (rsp_started_wait !== want.start_wait)
            flag_mismatch("started_wait", area_type'(rsp_started_wait),
                          area_type'(want.start_wait));
         if (rsp_store_overflow !== want.overflow)
            flag_mismatch("store_overflow", area_type'(rsp_store_overflow),
                          area_type'(want.overflow));
         if (rsp_served_total !== want.served)
            flag_mismatch("served_total", area_type'(rsp_served_total),
                          area_type'(want.served));
         if (rsp_longest_queue !== want.longest)
            flag_mismatch("longest_queue", area_type'(rsp_longest_queue),
                          area_type'(want.longest));
         if (rsp_queue_area !== want.q_area)
            flag_mismatch("queue_area", rsp_queue_area, want.q_area);
         if (rsp_system_area !== want.sys_area)
            flag_mismatch("system_area", rsp_system_area, want.sys_area);
         if (rsp_idle_area !== want.idle_area)
            flag_mismatch("idle_area", rsp_idle_area, want.idle_area);
         if (rsp_wait_sum !== want.waits)
            flag_mismatch("wait_sum", rsp_wait_sum, want.waits);
         if (rsp_empty_queue_time !== want.empty_time)
            flag_mismatch("empty_queue_time", rsp_empty_queue_time, want.empty_time);
      end
   endtask

   // Results are checked before new items are predicted, so a result can never
   // be matched against an item taken at the same edge.
   always @(posedge clock) begin
      if (reset) begin
         servers_cfg = FREE_W'(1);
         clear_run();
         expected_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) check_result();
         if (csr_valid && csr_ready) begin
            // A new server count starts a fresh run without a report.
            servers_cfg = csr_server_count;
            clear_run();
         end
         if (req_valid && req_ready) apply_item(req_type, req_event_time, req_carried_delay);
      end
      outstanding = expected_q.size();
   end

endmodule

FILE: tb/multi_server_queue_statistics_tb.sv
`timescale 1ns / 1ps

module multi_server_queue_statistics_tb;
   import msqs_pkg::*;

   // Request code that the block ignores apart from reporting.
   localparam logic [KIND_W-1:0] EV_UNUSED = 2'd3;
   localparam int STORE_DEPTH     = 1024;
   localparam int PRESSURE_CYCLES = 300;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int SETTLE_CYCLES   = 8;

   logic                 clock;
   logic                 reset            = 1'b1;
   logic                 csr_valid        = 1'b0;
   logic                 csr_ready;
   logic [FREE_W-1:0]    csr_server_count = '0;
   logic                 req_valid        = 1'b0;
   logic                 req_ready;
   logic [KIND_W-1:0]    req_type         = '0;
   logic [TIME_IN_W-1:0] req_event_time   = '0;
   logic [TIME_IN_W-1:0] req_carried_delay = '0;
   logic                 rsp_valid;
   logic                 rsp_ready        = 1'b0;
   logic                 rsp_service_started;
   logic [TIME_IN_W-1:0] rsp_started_wait;
   logic                 rsp_store_overflow;
   logic [COUNT_W-1:0]   rsp_served_total;
   logic [LONGEST_W-1:0] rsp_longest_queue;
   logic [AREA_W-1:0]    rsp_queue_area;
   logic [AREA_W-1:0]    rsp_system_area;
   logic [AREA_W-1:0]    rsp_idle_area;
   logic [AREA_W-1:0]    rsp_wait_sum;
   logic [AREA_W-1:0]    rsp_empty_queue_time;

   int                   mismatches;
   int                   in_flight;
   int                   quiet_cycles = 0;
   int                   req_gap_pct  = 0;
   int                   rsp_gap_pct  = 0;
   bit                   hold_rsp     = 1'b0;
   logic [TIME_IN_W-1:0] sim_now      = '0;

   multi_server_queue_statistics dut (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_server_count    (csr_server_count),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_type            (req_type),
      .req_event_time      (req_event_time),
      .req_carried_delay   (req_carried_delay),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_service_started (rsp_service_started),
      .rsp_started_wait    (rsp_started_wait),
      .rsp_store_overflow  (rsp_store_overflow),
      .rsp_served_total    (rsp_served_total),
      .rsp_longest_queue   (rsp_longest_queue),
      .rsp_queue_area      (rsp_queue_area),
      .rsp_system_area     (rsp_system_area),
      .rsp_idle_area       (rsp_idle_area),
      .rsp_wait_sum        (rsp_wait_sum),
      .rsp_empty_queue_time(rsp_empty_queue_time)
   );

   multi_server_queue_statistics_checker stats_check (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_server_count    (csr_server_count),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_type            (req_type),
      .req_event_time      (req_event_time),
      .req_carried_delay   (req_carried_delay),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_service_started (rsp_service_started),
      .rsp_started_wait    (rsp_started_wait),
      .rsp_store_overflow  (rsp_store_overflow),
      .rsp_served_total    (rsp_served_total),
      .rsp_longest_queue   (rsp_longest_queue),
      .rsp_queue_area      (rsp_queue_area),
      .rsp_system_area     (rsp_system_area),
      .rsp_idle_area       (rsp_idle_area),
      .rsp_wait_sum        (rsp_wait_sum),
      .rsp_empty_queue_time(rsp_empty_queue_time),
      .fail_count          (mismatches),
      .outstanding         (in_flight)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int gap_length();
      return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(12, 50);
   endfunction

   // Station clock: mostly small forward steps, some large ones, a few stale
   // stamps and a few jumps to anywhere in the 32-bit range.
   function automatic logic [TIME_IN_W-1:0] next_time();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         sim_now = $urandom();
         return sim_now;
      end
      if (pick < 8) return sim_now - $urandom_range(1, 32'h0004_0000);
      if (pick < 20) sim_now += $urandom_range(0, 32'h00FF_FFFF);
      else sim_now += $urandom_range(0, 32'h0003_FFFF);
      return sim_now;
   endfunction

   // Offer one item and hold it until the block takes it.
   task automatic send_item(logic [KIND_W-1:0] kind, logic [TIME_IN_W-1:0] t,
                            logic [TIME_IN_W-1:0] dly);
      int gap;
      if ($urandom_range(0, 99) < req_gap_pct) begin
         gap = gap_length();
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_type          <= kind;
      req_event_time    <= t;
      req_carried_delay <= dly;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      do @(posedge clock); while (in_flight != 0);
   endtask

   // The server count is only changed once every result has come back.
   task automatic set_servers(logic [FREE_W-1:0] count);
      req_valid <= 1'b0;
      drain();
      csr_valid        <= 1'b1;
      csr_server_count <= count;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sim_now = '0;
   endtask

   task automatic random_run(int count, int arrival_pct, int close_pct, int gaps_pct);
      int pick;
      req_gap_pct = gaps_pct;
      rsp_gap_pct = gaps_pct;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            send_item(EV_UNUSED, $urandom(), $urandom());
         end else if (pick < 3 + close_pct) begin
            send_item(EV_CLOSE, next_time(), $urandom());
            sim_now = '0;
         end else if (pick < 3 + close_pct + arrival_pct) begin
            send_item(EV_ARRIVAL, next_time(), $urandom());
         end else begin
            send_item(EV_DEPARTURE, next_time(), $urandom());
         end
      end
   endtask

   // Result side: random stalls, plus one long hold-off on request.
   initial begin : receiver
      int gap;
      bit held;
      held = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (hold_rsp && !held) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (PRESSURE_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if ($urandom_range(0, 99) < rsp_gap_pct) begin
            gap = gap_length();
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Ends the run when no item moves on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("multi_server_queue_statistics_tb failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed items with the single server left by reset.
      req_gap_pct = 30;
      rsp_gap_pct = 30;
      send_item(EV_ARRIVAL,   32'h0000_0000, 32'h0000_0000);  // served at once
      send_item(EV_ARRIVAL,   32'h0001_0000, 32'hFFFF_FFFF);  // first to wait
      send_item(EV_ARRIVAL,   32'h0002_8000, 32'h0000_0000);
      send_item(EV_DEPARTURE, 32'h0003_0000, 32'hFFFF_FFFF);  // starts a waiting one
      send_item(EV_DEPARTURE, 32'h0004_0000, 32'h0000_0000);  // queue runs empty
      send_item(EV_DEPARTURE, 32'h0005_0000, 32'h1234_5678);  // server goes idle
      send_item(EV_DEPARTURE, 32'h0006_0000, 32'hFFFF_FFFF);  // nobody in system
      send_item(EV_UNUSED,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(EV_ARRIVAL,   32'h0007_0000, 32'h0000_0000);
      send_item(EV_ARRIVAL,   32'h0008_0000, 32'h0000_0000);
      send_item(EV_ARRIVAL,   32'h0002_0000, 32'h0000_0000);  // clock runs backward
      send_item(EV_DEPARTURE, 32'h0001_0000, 32'hAAAA_5555);  // wait would be negative
      send_item(EV_DEPARTURE, 32'h0009_0000, 32'h5555_AAAA);
      send_item(EV_DEPARTURE, 32'h000A_0000, 32'h8000_0001);
      send_item(EV_ARRIVAL,   32'hFFFF_FFFF, 32'h0000_0000);
      send_item(EV_ARRIVAL,   32'hFFFF_FFFF, 32'h0000_0000);
      send_item(EV_CLOSE,     32'hFFFF_FFFF, 32'h0000_0000);  // close with one waiting
      send_item(EV_CLOSE,     32'h0000_0000, 32'h0000_0000);  // close of an empty run
      send_item(EV_ARRIVAL,   32'h0000_0001, 32'h0000_0000);
      send_item(EV_DEPARTURE, 32'h0000_0002, 32'h8000_0000);
      send_item(EV_CLOSE,     32'h0000_0003, 32'h0000_0000);

      // No servers: every arrival waits until the store is full and then
      // overflows; mixed traffic afterwards moves both store pointers on.
      set_servers('0);
      req_gap_pct = 10;
      rsp_gap_pct = 10;
      for (int n = 0; n < STORE_DEPTH + 4; n++) begin
         send_item(EV_ARRIVAL, next_time(), $urandom());
      end
      random_run(50, 48, 0, 20);
      send_item(EV_CLOSE, next_time(), $urandom());

      // Many servers, with one long hold-off on the result side.
      set_servers(FREE_W'(64));
      hold_rsp = 1'b1;
      random_run(40, 60, 2, 25);

      // One server and no idling on either side.
      set_servers(FREE_W'(1));
      random_run(30, 52, 1, 0);

      set_servers(FREE_MAX);
      random_run(20, 60, 3, 25);

      set_servers(FREE_W'($urandom_range(2, 63)));
      random_run(20, 50, 4, 40);

      set_servers(FREE_W'(2));
      random_run(20, 51, 1, 15);

      req_valid <= 1'b0;
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("multi_server_queue_statistics_tb passed");
      end else begin
         $display("multi_server_queue_statistics_tb failed");
      end
      $finish;
   end

endmodule
